// ===== hw/rtl/ucep_pkg.sv =====
// ----------------------------------------------------------------------------
// ucep_pkg
// Types and constants shared by the endpoint-0 control transfer handler.
// ----------------------------------------------------------------------------
package ucep_pkg;

   localparam int MAX_PACKET_DEF = 8;

   typedef enum logic [1:0] {
      KIND_BUS_RESET = 2'd0,
      KIND_SETUP     = 2'd1,
      KIND_OUT_DONE  = 2'd2,
      KIND_IN_DONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_IN   = 2'd1,
      DIR_OUT  = 2'd2
   } dir_type;

   typedef enum logic [2:0] {
      ACT_RESET   = 3'd0,
      ACT_START   = 3'd1,
      ACT_NODATA  = 3'd2,
      ACT_STALL   = 3'd3,
      ACT_OUT     = 3'd4,
      ACT_IN      = 3'd5
   } act_type;

   localparam logic [7:0] REQ_GET_DESC   = 8'h06;
   localparam logic [7:0] REQ_SET_ADDR   = 8'h05;
   localparam logic [7:0] REQ_SET_CONFIG = 8'h09;
   localparam logic [7:0] REQ_GET_CONFIG = 8'h08;
   localparam logic [7:0] CLS_GET_REPORT = 8'h81;
   localparam logic [7:0] CLS_SET_IDLE   = 8'h8A;

   localparam logic [7:0] CLASS_MASK  = 8'h60;
   localparam logic [7:0] CLASS_VALUE = 8'h20;
   localparam logic [7:0] CLASS_BIT   = 8'h80;

   localparam logic [7:0] DT_DEVICE = 8'h01;
   localparam logic [7:0] DT_CONFIG = 8'h02;
   localparam logic [7:0] DT_STRING = 8'h03;
   localparam logic [7:0] DT_REPORT = 8'h22;

   // classified command handed from front to back
   typedef struct packed {
      act_type     act;
      logic [3:0]  src;
      logic [7:0]  len;      // already clamped to wLength
      logic        set_addr;
      logic        set_cfg;
      logic [7:0]  value;
   } cmd_type;

   typedef struct packed {
      logic        in_arm;
      logic        in_stall;
      logic [3:0]  in_count;
      logic        in_toggle;
      logic [3:0]  out_count;
      logic        out_toggle_check;
      logic        out_toggle;
      logic [3:0]  data_source;
      logic [7:0]  source_offset;
      logic        address_apply;
      logic [6:0]  device_address;
      logic [7:0]  configuration_value;
   } rsp_type;

endpackage

// ===== hw/rtl/ucep_front.sv =====
// ----------------------------------------------------------------------------
// ucep_front
// Decodes one endpoint-0 event into a command for the transfer sequencer.
// ----------------------------------------------------------------------------
module ucep_front (
   input  logic [1:0]        kind,
   input  logic [7:0]        request_type,
   input  logic [7:0]        request,
   input  logic [15:0]       setup_value,
   input  logic [15:0]       setup_length,
   output ucep_pkg::cmd_type cmd
);
   import ucep_pkg::*;

   logic [7:0] req;
   logic [7:0] full_len;
   logic       data_in;

   always_comb begin
      req = request;
      if ((request_type & CLASS_MASK) == CLASS_VALUE) req = request | CLASS_BIT;
      cmd = '0;
      cmd.value = setup_value[7:0];
      full_len = 8'd0;
      data_in = 1'b0;
      case (kind_type'(kind))
         KIND_BUS_RESET: cmd.act = ACT_RESET;
         KIND_OUT_DONE:  cmd.act = ACT_OUT;
         KIND_IN_DONE:   cmd.act = ACT_IN;
         default: begin
            cmd.act = ACT_STALL;
            case (req)
               REQ_GET_DESC: begin
                  data_in = 1'b1;
                  case (setup_value[15:8])
                     DT_DEVICE: begin cmd.src = 4'd1; full_len = 8'd18; end
                     DT_CONFIG: begin cmd.src = 4'd2; full_len = 8'd34; end
                     DT_REPORT: begin cmd.src = 4'd3; full_len = 8'd60; end
                     DT_STRING: begin
                        case (setup_value[7:0])
                           8'd0: begin cmd.src = 4'd4; full_len = 8'd4; end
                           8'd1: begin cmd.src = 4'd5; full_len = 8'd38; end
                           8'd2: begin cmd.src = 4'd6; full_len = 8'd52; end
                           8'd3: begin cmd.src = 4'd7; full_len = 8'd10; end
                           default: begin cmd.src = 4'd0; full_len = 8'd0; end
                        endcase
                     end
                     default: data_in = 1'b0;
                  endcase
               end
               REQ_SET_ADDR: begin cmd.act = ACT_NODATA; cmd.set_addr = 1'b1; end
               REQ_SET_CONFIG: begin cmd.act = ACT_NODATA; cmd.set_cfg = 1'b1; end
               CLS_SET_IDLE: cmd.act = ACT_NODATA;
               REQ_GET_CONFIG: begin data_in = 1'b1; cmd.src = 4'd8; full_len = 8'd1; end
               CLS_GET_REPORT: begin data_in = 1'b1; cmd.src = 4'd9; full_len = 8'd2; end
               default: cmd.act = ACT_STALL;
            endcase
            if (data_in) begin
               cmd.act = ACT_START;
               cmd.len = ({8'd0, full_len} > setup_length) ? setup_length[7:0] : full_len;
            end
         end
      endcase
   end

endmodule

// ===== hw/rtl/ucep_queue.sv =====
// ----------------------------------------------------------------------------
// ucep_queue
// Two-entry queue between the decoder and the transfer sequencer.
// ----------------------------------------------------------------------------
module ucep_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ucep_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output ucep_pkg::cmd_type pop_data
);
   import ucep_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

// ===== hw/rtl/ucep_back.sv =====
// ----------------------------------------------------------------------------
// ucep_back
// Transfer sequencer: keeps the control transfer state and builds responses.
// ----------------------------------------------------------------------------
module ucep_back #(
   parameter int MAX_PACKET = ucep_pkg::MAX_PACKET_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  ucep_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ucep_pkg::rsp_type rsp
);
   import ucep_pkg::*;

   localparam logic [7:0] PKT = 8'(MAX_PACKET);

   dir_type    dir_ff, dir_in, d;
   logic [3:0] src_ff, src_in, s;
   logic [7:0] pos_ff, pos_in, p;
   logic [7:0] rem_ff, rem_in, r;
   logic       tog_ff, tog_in, t;
   logic [6:0] padr_ff, padr_in;
   logic [7:0] cfg_ff, cfg_in;
   logic       vld_ff, vld_in;
   rsp_type    rsp_ff, rsp_in;
   logic [7:0] n;

   assign cmd_pop   = cmd_valid && (!vld_ff || rsp_ready);
   assign rsp_valid = vld_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      d = dir_ff; s = src_ff; p = pos_ff; r = rem_ff; t = tog_ff;
      padr_in = padr_ff; cfg_in = cfg_ff;
      rsp_in = '0;
      case (cmd.act)
         ACT_RESET: begin
            d = DIR_NONE; s = '0; p = '0; r = '0; t = 1'b0;
            padr_in = '0; cfg_in = '0;
         end
         ACT_START: begin d = DIR_IN; t = 1'b1; s = cmd.src; p = '0; r = cmd.len; end
         ACT_NODATA: begin
            d = DIR_OUT; t = 1'b1; s = '0; p = '0; r = '0;
            if (cmd.set_addr) padr_in = cmd.value[6:0];
            if (cmd.set_cfg) cfg_in = cmd.value;
         end
         ACT_STALL: begin d = DIR_NONE; t = 1'b1; s = '0; p = '0; r = '0; end
         ACT_OUT: begin
            if (dir_ff == DIR_IN) d = DIR_NONE;
            else if (dir_ff == DIR_OUT) t = ~tog_ff;
         end
         default: begin
            if (dir_ff == DIR_IN) t = ~tog_ff;
            else if (dir_ff == DIR_OUT) begin
               d = DIR_NONE;
               if (padr_ff != '0) begin
                  rsp_in.address_apply  = 1'b1;
                  rsp_in.device_address = padr_ff;
                  padr_in = '0;
               end
            end
         end
      endcase
      n = (r <= PKT) ? r : PKT;
      pos_in = p; rem_in = r;
      if (d == DIR_IN) begin
         rsp_in.in_arm = 1'b1;
         rsp_in.in_count = n[3:0];
         rsp_in.in_toggle = t;
         rsp_in.out_toggle_check = 1'b1;
         rsp_in.out_toggle = 1'b1;
         rsp_in.data_source = s;
         rsp_in.source_offset = p;
         pos_in = p + n;
         rem_in = r - n;
      end else if (d == DIR_OUT) begin
         rsp_in.in_arm = 1'b1;
         rsp_in.in_toggle = 1'b1;
         rsp_in.out_count = n[3:0];
         rsp_in.out_toggle_check = 1'b1;
         rsp_in.out_toggle = t;
      end else begin
         rsp_in.out_count = 4'd8;
         if (cmd.act == ACT_STALL) begin
            rsp_in.in_arm = 1'b1;
            rsp_in.in_stall = 1'b1;
         end
      end
      // bus reset strobes address 0
      if (cmd.act == ACT_RESET) rsp_in.address_apply = 1'b1;
      rsp_in.configuration_value = cfg_in;
      dir_in = d; src_in = s; tog_in = t;
      vld_in = cmd_pop || (vld_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_NONE; src_ff <= '0; pos_ff <= '0; rem_ff <= '0;
         tog_ff <= 1'b0; padr_ff <= '0; cfg_ff <= '0; vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (cmd_pop) begin
            dir_ff <= dir_in; src_ff <= src_in; pos_ff <= pos_in; rem_ff <= rem_in;
            tog_ff <= tog_in; padr_ff <= padr_in; cfg_ff <= cfg_in;
         end
      end
      if (cmd_pop) rsp_ff <= rsp_in;
   end

endmodule

// ===== hw/rtl/usb_control_endpoint_handler_core.sv =====
// ----------------------------------------------------------------------------
// usb_control_endpoint_handler_core
// Endpoint-0 control transfer handler of a low-speed USB device.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one endpoint-0 event per beat (bus reset, SETUP, OUT done,
//   IN done) with the SETUP fields. rsp_ returns one beat per event: how to
//   re-arm the endpoint buffers, the data source and offset of the next IN
//   packet, the address load strobe and the current configuration.
//   A decoder classifies each event into a two-entry command queue; the
//   sequencer pops one command per cycle into the response register while it is free or being taken.
//   Each accepted request is registered in the queue and then in the
//   response register; throughput is one event per cycle while rsp_tready
//   is high. When rsp_tready is low, the response register holds, the
//   queue fills and req_tready drops once two commands are waiting.
//   Synchronous reset clears all transfer state, empties the queue and
//   drops rsp_tvalid. A bus reset event clears the transfer state, not the
//   queue, and answers with address 0 strobed.
// ----------------------------------------------------------------------------
module usb_control_endpoint_handler_core #(
   parameter int MAX_PACKET = ucep_pkg::MAX_PACKET_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[1:0], request_type[9:2], request[17:10], setup_value[33:18],
   // setup_length[49:34], zero fill[55:50]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // in_arm[0], in_stall[1], in_count[5:2], in_toggle[6], out_count[10:7],
   // out_toggle_check[11], out_toggle[12], data_source[16:13],
   // source_offset[24:17], address_apply[25], device_address[32:26],
   // configuration_value[40:33], zero fill[47:41]
   output logic [47:0] rsp_tdata
);
   import ucep_pkg::*;

   cmd_type dec_cmd, q_cmd;
   rsp_type rsp;
   logic    q_full, q_empty, q_pop, push;

   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;

   ucep_front u_front (
      .kind(req_tdata[1:0]), .request_type(req_tdata[9:2]), .request(req_tdata[17:10]),
      .setup_value(req_tdata[33:18]), .setup_length(req_tdata[49:34]), .cmd(dec_cmd)
   );

   ucep_queue u_queue (
      .clock, .reset, .push, .push_data(dec_cmd), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_data(q_cmd)
   );

   ucep_back #(.MAX_PACKET(MAX_PACKET)) u_back (
      .clock, .reset, .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_pop(q_pop),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp
   );

   assign rsp_tdata = {7'd0, rsp.configuration_value, rsp.device_address, rsp.address_apply,
                       rsp.source_offset, rsp.data_source, rsp.out_toggle,
                       rsp.out_toggle_check, rsp.out_count, rsp.in_toggle, rsp.in_count,
                       rsp.in_stall, rsp.in_arm};

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_tready)
      else $error("accepted into full queue");
   a_stall_not_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0] && rsp_tdata[5:2] == 4'd0)
      else $error("stall without armed empty IN");

endmodule
